### rtl/ntt_bf_pkg.sv
// Shared constants for the modular NTT butterfly.
package ntt_bf_pkg;

  localparam int COEFF_WIDTH_DEF = 32;
  localparam int DATA_W          = 32;
  localparam int FUNC_W          = 2;

  localparam logic [DATA_W-1:0] MODULUS_RESET = 32'd998244353;

  // Butterfly function codes carried in the input tuser.
  localparam logic [FUNC_W-1:0] FUNC_CT      = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_GS      = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_GS_HALF = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_MUL     = 2'd3;

endpackage

### rtl/ntt_bf_modmul.sv
// Pipelined bit-serial modular multiplier, one multiplier bit per stage, MSB first.
module ntt_bf_modmul #(
  parameter int W      = ntt_bf_pkg::COEFF_WIDTH_DEF,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [W-1:0]      in_x,
  input  logic [W-1:0]      in_y,
  input  logic [SIDE_W-1:0] in_side,
  input  logic [W-1:0]      q,
  output logic              out_valid,
  output logic [W-1:0]      out_r,
  output logic [SIDE_W-1:0] out_side
);

  logic              v_r    [W];
  logic [W-1:0]      r_r    [W];
  logic [W-1:0]      x_r    [W];
  logic [W-1:0]      y_r    [W];
  logic [SIDE_W-1:0] side_r [W];

  // r <- (2r + bit*x) mod q; 2r + x < 3q, so at most two subtractions of q.
  function automatic logic [W-1:0] dbl_add(input logic [W-1:0] r, input logic [W-1:0] x,
                                           input logic [W-1:0] m, input logic b);
    logic [W+1:0] s;
    logic [W+1:0] m1;
    logic [W+1:0] m2;
    s  = {1'b0, r, 1'b0} + (b ? {2'b00, x} : '0);
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    priority if (s >= m2) begin
      dbl_add = W'(s - m2);
    end else if (s >= m1) begin
      dbl_add = W'(s - m1);
    end else begin
      dbl_add = W'(s);
    end
  endfunction

  for (genvar i = 0; i < W; i++) begin : g_st
    logic              v_in;
    logic [W-1:0]      r_in;
    logic [W-1:0]      x_in;
    logic [W-1:0]      y_in;
    logic [SIDE_W-1:0] side_in;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign r_in    = '0;
      assign x_in    = in_x;
      assign y_in    = in_y;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[i-1];
      assign r_in    = r_r[i-1];
      assign x_in    = x_r[i-1];
      assign y_in    = y_r[i-1];
      assign side_in = side_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[i]    <= dbl_add(r_in, x_in, q, y_in[W-1-i]);
        x_r[i]    <= x_in;
        y_r[i]    <= y_in;
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid = v_r[W-1];
  assign out_r     = r_r[W-1];
  assign out_side  = side_r[W-1];

endmodule

### rtl/modular_ntt_butterfly_top.sv
// Modular NTT butterfly (CT, GS, GS with halving, product) on a stream interface.
//
//  channel | dir | handshake               | payload
//  in      | in  | in_tvalid / in_tready   | tdata: a, b, w; tuser: func
//  out     | out | out_tvalid / out_tready | tdata: upper, lower; tuser: range_error
//  cfg     | in  | cfg_valid / cfg_ready   | cfg_data: modulus
//
// One item per cycle sustained while the output is not stalled.
// The modular multiplier handles one multiplier bit per pipeline stage.
// Synchronous active-low reset clears all valid bits and loads the default modulus.
// A stall on the output freezes the whole pipeline; in_tready follows out_tready
// whenever the output register is full.
module modular_ntt_butterfly_top #(
  parameter int COEFF_WIDTH = ntt_bf_pkg::COEFF_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [3*ntt_bf_pkg::DATA_W-1:0]  in_tdata,   // [31:0] a, [63:32] b, [95:64] w
  input  logic [ntt_bf_pkg::FUNC_W-1:0]    in_tuser,   // [1:0] func
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [2*ntt_bf_pkg::DATA_W-1:0]  out_tdata,  // [31:0] upper, [63:32] lower
  output logic                             out_tuser,  // [0] range_error
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ntt_bf_pkg::DATA_W-1:0]    cfg_data
);

  localparam int CW     = COEFF_WIDTH;
  localparam int DW     = ntt_bf_pkg::DATA_W;
  localparam int FW     = ntt_bf_pkg::FUNC_W;
  localparam int SIDE_W = FW + 1 + 2 * CW;

  function automatic logic [CW-1:0] add_mod(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                            input logic [CW-1:0] m);
    logic [CW:0] s;
    s = {1'b0, x} + {1'b0, y};
    add_mod = (s >= {1'b0, m}) ? CW'(s - {1'b0, m}) : CW'(s);
  endfunction

  function automatic logic [CW-1:0] sub_mod(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                            input logic [CW-1:0] m);
    sub_mod = (x >= y) ? (x - y) : CW'({1'b0, x} + {1'b0, m} - {1'b0, y});
  endfunction

  // x * 2^-1 mod m; odd values borrow one m before the shift
  function automatic logic [CW-1:0] half_mod(input logic [CW-1:0] x, input logic [CW-1:0] m);
    logic [CW:0] s;
    s = {1'b0, x} + {1'b0, m};
    half_mod = x[0] ? CW'(s >> 1) : (x >> 1);
  endfunction

  logic [DW-1:0] modulus_r;
  logic [CW-1:0] q;
  logic          en;

  assign cfg_ready = 1'b1;
  assign q         = CW'(modulus_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= ntt_bf_pkg::MODULUS_RESET;
    end else if (cfg_valid) begin
      modulus_r <= cfg_data;
    end
  end

  logic out_tvalid_r;
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // stage 1: capture
  logic          v1_r;
  logic [FW-1:0] f1_r;
  logic [CW-1:0] a1_r, b1_r, w1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r <= in_tuser;
      a1_r <= CW'(in_tdata[DW-1:0]);
      b1_r <= CW'(in_tdata[2*DW-1:DW]);
      w1_r <= CW'(in_tdata[3*DW-1:2*DW]);
    end
  end

  // stage 2: range check, sum and difference
  logic          v2_r, e2_r;
  logic [FW-1:0] f2_r;
  logic [CW-1:0] a2_r, b2_r, w2_r, sum2_r, diff2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_r    <= f1_r;
      e2_r    <= (a1_r >= q) || (b1_r >= q) || (w1_r >= q);
      a2_r    <= a1_r;
      b2_r    <= b1_r;
      w2_r    <= w1_r;
      sum2_r  <= add_mod(a1_r, b1_r, q);
      diff2_r <= sub_mod(a1_r, b1_r, q);
    end
  end

  // stage 3: halving and multiplier operand select
  logic              v3_r;
  logic [CW-1:0]     x3_r, y3_r;
  logic [SIDE_W-1:0] side3_r;
  logic [CW-1:0]     x3_nxt, up3_nxt;

  always_comb begin
    up3_nxt = sum2_r;
    unique case (f2_r)
      ntt_bf_pkg::FUNC_CT: begin
        x3_nxt = b2_r;
      end
      ntt_bf_pkg::FUNC_GS: begin
        x3_nxt = diff2_r;
      end
      ntt_bf_pkg::FUNC_GS_HALF: begin
        x3_nxt  = half_mod(diff2_r, q);
        up3_nxt = half_mod(sum2_r, q);
      end
      default: begin
        x3_nxt = a2_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x3_r    <= x3_nxt;
      y3_r    <= w2_r;
      side3_r <= {f2_r, e2_r, a2_r, up3_nxt};
    end
  end

  // multiplier pipeline: t = x * w mod q
  logic              vm;
  logic [CW-1:0]     tm;
  logic [SIDE_W-1:0] sidem;

  ntt_bf_modmul #(
    .W      (CW),
    .SIDE_W (SIDE_W)
  ) u_modmul (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_x      (x3_r),
    .in_y      (y3_r),
    .in_side   (side3_r),
    .q         (q),
    .out_valid (vm),
    .out_r     (tm),
    .out_side  (sidem)
  );

  // final stage: combine and register the result item
  logic [FW-1:0] fm;
  logic          em;
  logic [CW-1:0] am, upm;
  logic [CW-1:0] up_nxt, lo_nxt;

  assign {fm, em, am, upm} = sidem;

  always_comb begin
    unique case (fm)
      ntt_bf_pkg::FUNC_CT: begin
        up_nxt = add_mod(am, tm, q);
        lo_nxt = sub_mod(am, tm, q);
      end
      ntt_bf_pkg::FUNC_GS, ntt_bf_pkg::FUNC_GS_HALF: begin
        up_nxt = upm;
        lo_nxt = tm;
      end
      default: begin
        up_nxt = tm;
        lo_nxt = '0;
      end
    endcase
    if (em) begin
      up_nxt = '0;
      lo_nxt = '0;
    end
  end

  logic [2*DW-1:0] out_tdata_r;
  logic            out_tuser_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= {DW'(lo_nxt), DW'(up_nxt)};
      out_tuser_r <= em;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

### rtl/ntt_bf_checker.sv
// Port-level checks for the modular NTT butterfly, bound to the top level.
module ntt_bf_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [2*ntt_bf_pkg::DATA_W-1:0] out_tdata,
  input logic                            out_tuser,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [ntt_bf_pkg::DATA_W-1:0]   cfg_data
);

  localparam int DW = ntt_bf_pkg::DATA_W;

  // shadow of the modulus as seen on the config port
  logic [DW-1:0] mod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= ntt_bf_pkg::MODULUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mod_r <= cfg_data;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("range error item carries nonzero results");

  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      (out_tdata[DW-1:0] < mod_r) && (out_tdata[2*DW-1:DW] < mod_r))
    else $error("result not reduced below modulus");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input held off without an output stall");

endmodule

bind modular_ntt_butterfly_top ntt_bf_checker u_ntt_bf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .cfg_data   (cfg_data)
);
